// ===== design/kvrt_pkg.sv =====
package kvrt_pkg;

    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;
    localparam int STAT_W      = 2;
    localparam int USED_W      = 7;
    localparam int DEF_ENTRIES = 64;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_UPDATED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_LOOKUP   = 2'd3;

    // One request word as it travels down the cell chain.
    typedef struct packed {
        logic              valid;
        logic              func;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic              resolved;   // match, insert or final verdict taken
        logic              hit;
        logic [VAL_W-1:0]  found_value;
        logic [STAT_W-1:0] status;
        logic              used_done;  // used count captured
        logic [USED_W-1:0] used;
    } t_token;

endpackage

// ===== design/kvrt_if.sv =====
interface kvrt_req_if;
    import kvrt_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface kvrt_rsp_if;
    import kvrt_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic              hit;
    logic [VAL_W-1:0]  found_value;
    logic [USED_W-1:0] used_entries;

    modport source (output valid, output status, output hit, output found_value,
                    output used_entries, input ready);
    modport sink   (input valid, input status, input hit, input found_value,
                    input used_entries, output ready);
endinterface

// ===== design/kvrt_cell.sv =====
module kvrt_cell #(
    parameter int ENTRIES = kvrt_pkg::DEF_ENTRIES,
    parameter int CNT_W   = $clog2(kvrt_pkg::DEF_ENTRIES + 1),
    parameter int IDX     = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [CNT_W-1:0]  i_count,
    input  kvrt_pkg::t_token  i_tok,
    output kvrt_pkg::t_token  o_tok,
    output logic              o_ins
);
    import kvrt_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
    localparam logic             IS_LAST = (IDX == ENTRIES - 1);

    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic             r_vld;
    t_token           r_tok;

    t_token n_tok;
    logic   entry_live;
    logic   at_fill;
    logic   ins;
    logic   wr_val;

    assign entry_live = (i_count > MY_IDX);
    assign at_fill    = (i_count == MY_IDX);

    always_comb begin
        n_tok  = i_tok;
        ins    = 1'b0;
        wr_val = 1'b0;
        if (i_tok.valid) begin
            if (!i_tok.resolved && entry_live && (r_key == i_tok.key)) begin
                n_tok.resolved = 1'b1;
                n_tok.hit      = 1'b1;
                if (i_tok.func == FUNC_LOOKUP) begin
                    n_tok.found_value = r_value;
                    n_tok.status      = ST_LOOKUP;
                end else begin
                    wr_val       = 1'b1;
                    n_tok.status = ST_UPDATED;
                end
            end else if (!i_tok.resolved && at_fill) begin
                // first free slot: append on add, miss on lookup
                n_tok.resolved = 1'b1;
                if (i_tok.func == FUNC_ADD) begin
                    ins          = 1'b1;
                    n_tok.status = ST_INSERTED;
                end else begin
                    n_tok.status = ST_LOOKUP;
                end
            end
            // everything ahead has settled once the word stands at the fill point
            if (!i_tok.used_done && (at_fill || IS_LAST)) begin
                n_tok.used_done = 1'b1;
                n_tok.used      = USED_W'(i_count) + USED_W'(ins);
            end
            if (!n_tok.resolved && IS_LAST) begin
                n_tok.resolved = 1'b1;
                n_tok.status   = (i_tok.func == FUNC_ADD) ? ST_FULL : ST_LOOKUP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok <= n_tok;
            if (ins) begin
                r_key <= i_tok.key;
            end
            if (ins || wr_val) begin
                r_value <= i_tok.value;
            end
        end
    end

    always_comb begin
        o_tok       = r_tok;
        o_tok.valid = r_vld;
    end

    assign o_ins = ins & i_adv;

endmodule

// ===== design/key_value_registry_table.sv =====
// Channel  Dir  Fields                                    Accepted when
// i_req    in   func, key, value                          valid & ready
// o_rsp    out  status, hit, found_value, used_entries    valid & ready
//
// A request word enters every cycle unless the output stalls; each result passes
// through the register of every cell of the chain and then the output register.
// Reset clears the entry count and the chain's valid flags; stored keys are
// undefined and only entries below the count are ever compared.
// A stalled output freezes the whole chain; i_req.ready is low only then.
module key_value_registry_table #(
    parameter int ENTRIES = kvrt_pkg::DEF_ENTRIES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    kvrt_req_if.sink   i_req,
    kvrt_rsp_if.source o_rsp
);
    import kvrt_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [CNT_W-1:0]   r_count;
    logic               r_out_vld;
    t_token             r_out;

    logic               adv;
    t_token             w_tok [0:ENTRIES];
    logic [ENTRIES-1:0] w_ins;

    assign adv         = !r_out_vld || o_rsp.ready;
    assign i_req.ready = adv;

    always_comb begin
        w_tok[0]             = '0;
        w_tok[0].valid       = i_req.valid;
        w_tok[0].func        = i_req.func;
        w_tok[0].key         = i_req.key;
        w_tok[0].value       = i_req.value;
        w_tok[0].status      = ST_LOOKUP;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        kvrt_cell #(
            .ENTRIES (ENTRIES),
            .CNT_W   (CNT_W),
            .IDX     (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_count (r_count),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .o_ins   (w_ins[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (|w_ins) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (adv) begin
                r_out_vld <= w_tok[ENTRIES].valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= w_tok[ENTRIES];
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.hit          = r_out.hit;
    assign o_rsp.found_value  = r_out.found_value;
    assign o_rsp.used_entries = r_out.used;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("entry count beyond capacity");

    a_one_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_ins))
        else $error("more than one cell appended in a cycle");

    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(ENTRIES)) |-> !(|w_ins))
        else $error("append into a full table");

    a_count_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_count))
        else $error("entry count moved during a stall");

    a_out_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.resolved && r_out.used_done))
        else $error("result word left the chain unsettled");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import kvrt_pkg::*;

    localparam int NUM_ENTRIES = DEF_ENTRIES;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_GAP     = 18;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic              hit;
        logic [VAL_W-1:0]  found_value;
        logic [USED_W-1:0] used_entries;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    kvrt_req_if req_ch ();
    kvrt_rsp_if rsp_ch ();

    key_value_registry_table #(
        .ENTRIES(NUM_ENTRIES)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // Shadow copy of the table
    logic [KEY_W-1:0] shadow_keys [NUM_ENTRIES];
    logic [VAL_W-1:0] shadow_vals [NUM_ENTRIES];
    int               shadow_count;

    t_result          pending_results[$];
    logic [KEY_W-1:0] key_pool[$];

    int fail_cnt;
    int cycle_cnt;
    int req_gap_max;
    int rsp_gap_max;
    int rsp_hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_result registry_apply(input logic func,
                                               input logic [KEY_W-1:0] key,
                                               input logic [VAL_W-1:0] value);
        t_result r;
        int pos;
        int i;
        pos = -1;
        for (i = 0; i < shadow_count; i++)
            if (pos < 0 && shadow_keys[i] == key)
                pos = i;
        r.hit         = (pos >= 0);
        r.found_value = '0;
        if (func == FUNC_LOOKUP) begin
            r.status = ST_LOOKUP;
            if (pos >= 0)
                r.found_value = shadow_vals[pos];
        end else if (pos >= 0) begin
            shadow_vals[pos] = value;
            r.status = ST_UPDATED;
        end else if (shadow_count < NUM_ENTRIES) begin
            shadow_keys[shadow_count] = key;
            shadow_vals[shadow_count] = value;
            shadow_count++;
            r.status = ST_INSERTED;
        end else begin
            r.status = ST_FULL;
        end
        r.used_entries = USED_W'(shadow_count);
        return r;
    endfunction

    // Leaves valid high after acceptance; the next call or req_idle settles it
    // in the same step.
    task automatic send_word(input logic func, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] value);
        int gap;
        gap = $urandom_range(0, req_gap_max);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= func;
        req_ch.key   <= key;
        req_ch.value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_results.push_back(registry_apply(func, key, value));
    endtask

    task automatic req_idle();
        req_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        req_idle();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Mostly known keys so adds update and lookups hit; near-miss keys differ by
    // one bit to exercise every compare bit.
    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        logic [KEY_W-1:0] k;
        sel = $urandom_range(0, 99);
        if (sel < 55 && key_pool.size() != 0) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else if (sel < 70 && key_pool.size() != 0) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            k[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
        end else if (sel < 75) begin
            case ($urandom_range(0, 2))
                0: k = '0;
                1: k = '1;
                default: k = 64'd1 << $urandom_range(0, KEY_W - 1);
            endcase
        end else begin
            k = {$urandom, $urandom};
        end
        return k;
    endfunction

    task automatic send_random_word();
        logic func;
        logic [KEY_W-1:0] key;
        func = ($urandom_range(0, 99) < 55) ? FUNC_ADD : FUNC_LOOKUP;
        key  = pick_key();
        if (func == FUNC_ADD)
            key_pool.push_back(key);
        send_word(func, key, rand_value());
    endtask

    // Result side: random stall per word, or a long hold-off when requested
    initial begin
        int stall;
        t_result exp;
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n);
        forever begin
            if (rsp_hold_cycles > 0) begin
                stall = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end else begin
                stall = $urandom_range(0, rsp_gap_max);
            end
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_ch.valid && rsp_ch.ready));
            if (pending_results.size() == 0) begin
                $error("unexpected result word: status %0d", rsp_ch.status);
                fail_cnt++;
            end else begin
                exp = pending_results.pop_front();
                if (rsp_ch.status !== exp.status) begin
                    $error("status: expected %0d, got %0d", exp.status, rsp_ch.status);
                    fail_cnt++;
                end
                if (rsp_ch.hit !== exp.hit) begin
                    $error("hit: expected %0d, got %0d", exp.hit, rsp_ch.hit);
                    fail_cnt++;
                end
                if (rsp_ch.found_value !== exp.found_value) begin
                    $error("found_value: expected %h, got %h", exp.found_value,
                           rsp_ch.found_value);
                    fail_cnt++;
                end
                if (rsp_ch.used_entries !== exp.used_entries) begin
                    $error("used_entries: expected %0d, got %0d", exp.used_entries,
                           rsp_ch.used_entries);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic test_directed_extremes();
        req_gap_max = MAX_GAP;
        rsp_gap_max = MAX_GAP;
        send_word(FUNC_LOOKUP, '0, '1);                     // lookup on empty table
        send_word(FUNC_ADD, '0, '1);
        send_word(FUNC_ADD, '1, '0);
        send_word(FUNC_LOOKUP, '0, 64'h1234);               // value ignored on lookup
        send_word(FUNC_LOOKUP, '1, '1);
        send_word(FUNC_ADD, '0, 64'h5555_5555_5555_5555);   // update
        send_word(FUNC_LOOKUP, '0, '0);
        send_word(FUNC_LOOKUP, 64'd1, '0);                  // miss
        send_word(FUNC_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(FUNC_ADD, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
        send_word(FUNC_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        send_word(FUNC_LOOKUP, 64'h5555_5555_5555_5555, '0);
        send_word(FUNC_LOOKUP, 64'h8000_0000_0000_0000, '0); // one bit off all-zero key
        send_word(FUNC_ADD, '1, '1);
        send_word(FUNC_LOOKUP, '1, '0);
        key_pool.push_back('0);
        key_pool.push_back('1);
        key_pool.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        key_pool.push_back(64'h5555_5555_5555_5555);
    endtask

    task automatic test_receiver_backpressure();
        int n;
        req_gap_max = 0;
        rsp_hold_cycles = 400;
        for (n = 0; n < 100; n++)
            send_random_word();
        req_gap_max = MAX_GAP;
    endtask

    task automatic test_drain_pause();
        int n;
        for (n = 0; n < 10; n++)
            send_random_word();
        wait_drained();
        for (n = 0; n < 10; n++)
            send_random_word();
    endtask

    task automatic test_random_traffic();
        int n;
        for (n = 0; n < 180; n++) begin
            // alternate idle-heavy and back-to-back stretches
            if (n % 40 == 0) begin
                req_gap_max = ((n / 40) % 2 == 0) ? MAX_GAP : 0;
                rsp_gap_max = ((n / 40) % 2 == 0) ? MAX_GAP : 0;
            end
            send_random_word();
        end
        req_gap_max = MAX_GAP;
        rsp_gap_max = MAX_GAP;
    endtask

    task automatic test_fill_to_capacity();
        logic [KEY_W-1:0] key;
        while (shadow_count < NUM_ENTRIES) begin
            key = {$urandom, $urandom};
            key_pool.push_back(key);
            send_word(FUNC_ADD, key, rand_value());
        end
    endtask

    task automatic test_full_table();
        int n;
        logic [KEY_W-1:0] key;
        for (n = 0; n < 120; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                key = {$urandom, $urandom};                 // fresh key, dropped
                key_pool.push_back(key);
                send_word(FUNC_ADD, key, rand_value());
            end else begin
                send_random_word();
            end
        end
    endtask

    initial begin
        fail_cnt        = 0;
        cycle_cnt       = 0;
        shadow_count    = 0;
        req_gap_max     = MAX_GAP;
        rsp_gap_max     = MAX_GAP;
        rsp_hold_cycles = 0;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func  <= FUNC_ADD;
        req_ch.key   <= '0;
        req_ch.value <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_receiver_backpressure();
        test_drain_pause();
        test_random_traffic();
        test_fill_to_capacity();
        test_full_table();

        wait_drained();
        repeat (NUM_ENTRIES + 20) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
